/* hw/rtl/least_squares_plane_fit_unit_macros.svh */
// Assertion macros shared by the plane fit checker.
`ifndef LEAST_SQUARES_PLANE_FIT_UNIT_MACROS_SVH
`define LEAST_SQUARES_PLANE_FIT_UNIT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next cycle.
`define LSPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plane fit: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define LSPF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plane fit: same-cycle check failed");

// Condition that must hold in the cycle after reset is asserted.
`define LSPF_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("plane fit: reset check failed");

`endif

/* hw/rtl/lspf_pkg.sv */
// Shared constants, item types and state encodings of the plane fit unit.
package lspf_pkg;

  localparam int MAX_POINTS     = 16;
  localparam int MIN_FIT_POINTS = 3;
  localparam int COORD_W        = 24;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int SUM1_W         = 29;
  localparam int SUM2_W         = 52;
  localparam int CNT_W          = $clog2(MAX_POINTS + 1);
  localparam int FRAC_BITS      = 16;
  localparam int ENT_W          = 64;
  localparam int BIG_W          = 192;
  localparam int RES_W          = 32;
  localparam int MIN_DET_W      = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int MAC_STEPS      = 9;
  localparam int NUM_DETS       = 4;
  localparam int NUM_QUOTS      = 3;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_FEW  = 3'd1,
    ST_SING = 3'd2,
    ST_SAT  = 3'd3,
    ST_MANY = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [RES_W-1:0] slope_x;
    logic signed [RES_W-1:0] slope_y;
    logic signed [RES_W-1:0] offset;
    status_t                 fit_status;
  } fit_t;

  // One finished point set as handed from the accumulator to the solver.
  typedef struct packed {
    logic [SUM1_W-1:0] sx;
    logic [SUM1_W-1:0] sy;
    logic [SUM1_W-1:0] sz;
    logic [SUM2_W-1:0] sxx;
    logic [SUM2_W-1:0] syy;
    logic [SUM2_W-1:0] sxy;
    logic [SUM2_W-1:0] sxz;
    logic [SUM2_W-1:0] syz;
    logic [CNT_W-1:0]  cnt;
    logic              ovf;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } f_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MLOAD,
    B_MRUN,
    B_MACC,
    B_SING,
    B_DLOAD,
    B_DRUN,
    B_DFIN,
    B_OUT
  } b_state_t;

endpackage

/* hw/rtl/least_squares_plane_fit_unit.sv */
// Top level of the least-squares plane fit unit.
//
//   channel   ports                        direction  handshake
//   point     start, busy, in_point        in         start && !busy
//   result    out_valid, out_fit           out        strobe, one cycle, no back-pressure
//   config    cfg_valid, cfg_ready, cfg_data in       cfg_valid && cfg_ready
//
// In the accumulator a point is captured, and then one 24x24 multiplier forms
// x*x, y*y, x*y, x*z and y*z in turn.
// A last point then hands its set to the queue, waiting while the queue is full.
// A full fit in the solver runs 36 bit-serial 64-step multiply-accumulates
// and three 192-step divisions.
// Point sets that fail early (too many or too few points) skip both and go straight to the result.
// The queue holds two finished point sets, so the accumulator keeps taking
// points while the solver works; busy is high during the multiply steps of
// each point and, after a last point, until the queue takes its set.
// Reset is synchronous and active low; it clears all sums, the queue and the
// state machines, and sets min_determinant to 1. The receiver cannot stall.
module least_squares_plane_fit_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lspf_pkg::point_t                in_point,
  output logic                            out_valid,
  output lspf_pkg::fit_t                  out_fit,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lspf_pkg::MIN_DET_W-1:0]  cfg_data
);
  import lspf_pkg::*;

  logic [MIN_DET_W-1:0] min_det_r;

  logic push;
  job_t push_job;
  logic q_full;
  logic q_pop;
  job_t q_data;
  logic q_empty;

  // The threshold register can always take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r <= MIN_DET_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      min_det_r <= cfg_data;
    end
  end

  // The accumulator hands over a finished point set and clears its sums.
  lspf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_point   (in_point),
    .push       (push),
    .push_job   (push_job),
    .push_ready (!q_full)
  );

  lspf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_job),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // The solver works one point set at a time and strobes a single result.
  lspf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_det   (min_det_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_fit   (out_fit)
  );

endmodule

/* hw/rtl/lspf_queue.sv */
// Small job queue between the point accumulator and the solver.
module lspf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  lspf_pkg::job_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output lspf_pkg::job_t rd_data,
  output logic          empty
);
  import lspf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  assign full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + FILL_W'(wr_en && !full) - FILL_W'(rd_en && !empty);
    end
  end

endmodule

/* hw/rtl/lspf_front.sv */
// Point accumulator: takes items and builds the running sums with one shared multiplier.
module lspf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lspf_pkg::point_t in_point,
  output logic            push,
  output lspf_pkg::job_t  push_job,
  input  logic            push_ready
);
  import lspf_pkg::*;

  f_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  logic                      last_r;
  logic                      add_r;
  logic [2:0]                step_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [SUM1_W-1:0]         sx_r, sy_r, sz_r;
  logic [SUM2_W-1:0]         sxx_r, syy_r, sxy_r, sxz_r, syz_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      ovf_r;

  logic signed [COORD_W-1:0] op_a, op_b;
  logic [SUM2_W-1:0]         prod_ext;
  logic                      accept;

  assign accept   = (state_r == F_IDLE) && start;
  assign prod_ext = SUM2_W'(prod_r);

  always_comb begin
    unique case (step_r)
      3'd0:    begin op_a = x_r; op_b = x_r; end
      3'd1:    begin op_a = y_r; op_b = y_r; end
      3'd2:    begin op_a = x_r; op_b = y_r; end
      3'd3:    begin op_a = x_r; op_b = z_r; end
      3'd4:    begin op_a = y_r; op_b = z_r; end
      default: begin op_a = '0;  op_b = '0;  end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (start) state_nxt = F_MUL;
      F_MUL: begin
        if (step_r == 3'd5) state_nxt = last_r ? F_PUSH : F_IDLE;
      end
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != F_IDLE);
    push = (state_r == F_PUSH);
  end

  assign push_job = '{sx: sx_r, sy: sy_r, sz: sz_r, sxx: sxx_r, syy: syy_r,
                      sxy: sxy_r, sxz: sxz_r, syz: syz_r, cnt: cnt_r, ovf: ovf_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_point.point_x;
      y_r    <= in_point.point_y;
      z_r    <= in_point.point_z;
      last_r <= in_point.last_point;
    end
    prod_r <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r   <= '0;
      sy_r   <= '0;
      sz_r   <= '0;
      sxx_r  <= '0;
      syy_r  <= '0;
      sxy_r  <= '0;
      sxz_r  <= '0;
      syz_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      add_r  <= 1'b0;
      step_r <= '0;
    end else begin
      if (accept) begin
        step_r <= '0;
        if (cnt_r < CNT_W'(MAX_POINTS)) begin
          add_r <= 1'b1;
          sx_r  <= sx_r + SUM1_W'(in_point.point_x);
          sy_r  <= sy_r + SUM1_W'(in_point.point_y);
          sz_r  <= sz_r + SUM1_W'(in_point.point_z);
          cnt_r <= cnt_r + 1'b1;
        end else begin
          add_r <= 1'b0;
          ovf_r <= 1'b1;
        end
      end else if (state_r == F_MUL) begin
        step_r <= step_r + 1'b1;
        // The product of the previous step lands in its sum now.
        if (add_r) begin
          unique case (step_r)
            3'd1:    sxx_r <= sxx_r + prod_ext;
            3'd2:    syy_r <= syy_r + prod_ext;
            3'd3:    sxy_r <= sxy_r + prod_ext;
            3'd4:    sxz_r <= sxz_r + prod_ext;
            3'd5:    syz_r <= syz_r + prod_ext;
            default: ;
          endcase
        end
      end else if ((state_r == F_PUSH) && push_ready) begin
        sx_r  <= '0;
        sy_r  <= '0;
        sz_r  <= '0;
        sxx_r <= '0;
        syy_r <= '0;
        sxy_r <= '0;
        sxz_r <= '0;
        syz_r <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/lspf_back.sv */
// Solver: exact 3x3 determinants on a bit-serial multiplier, then restoring division.
module lspf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lspf_pkg::MIN_DET_W-1:0]  min_det,
  input  logic                            q_empty,
  input  lspf_pkg::job_t                  q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  output lspf_pkg::fit_t                  out_fit
);
  import lspf_pkg::*;

  localparam int STEP_W = $clog2(MAC_STEPS);
  localparam int MBIT_W = $clog2(ENT_W);
  localparam int DBIT_W = $clog2(BIG_W);

  typedef struct packed {
    logic       a_from_t;
    logic [1:0] a_sel;
    logic [1:0] a_row;
    logic [1:0] a_col;
    logic [1:0] b_row;
    logic [1:0] b_col;
    logic       neg;
    logic       clr;
    logic       st_t;
    logic [1:0] t_idx;
    logic       fin;
  } mac_op_t;

  // Cofactor expansion along the first row, one multiply-accumulate per step.
  function automatic mac_op_t mac_op(input logic [STEP_W-1:0] s);
    mac_op_t o;
    o = '0;
    unique case (s)
      4'd0: begin o.a_row = 2'd1; o.a_col = 2'd1; o.b_row = 2'd2; o.b_col = 2'd2;
                  o.clr = 1'b1; end
      4'd1: begin o.a_row = 2'd1; o.a_col = 2'd2; o.b_row = 2'd2; o.b_col = 2'd1;
                  o.neg = 1'b1; o.st_t = 1'b1; o.t_idx = 2'd0; end
      4'd2: begin o.a_row = 2'd1; o.a_col = 2'd0; o.b_row = 2'd2; o.b_col = 2'd2;
                  o.clr = 1'b1; end
      4'd3: begin o.a_row = 2'd1; o.a_col = 2'd2; o.b_row = 2'd2; o.b_col = 2'd0;
                  o.neg = 1'b1; o.st_t = 1'b1; o.t_idx = 2'd1; end
      4'd4: begin o.a_row = 2'd1; o.a_col = 2'd0; o.b_row = 2'd2; o.b_col = 2'd1;
                  o.clr = 1'b1; end
      4'd5: begin o.a_row = 2'd1; o.a_col = 2'd1; o.b_row = 2'd2; o.b_col = 2'd0;
                  o.neg = 1'b1; o.st_t = 1'b1; o.t_idx = 2'd2; end
      4'd6: begin o.a_from_t = 1'b1; o.a_sel = 2'd0; o.b_row = 2'd0; o.b_col = 2'd0;
                  o.clr = 1'b1; end
      4'd7: begin o.a_from_t = 1'b1; o.a_sel = 2'd1; o.b_row = 2'd0; o.b_col = 2'd1;
                  o.neg = 1'b1; end
      4'd8: begin o.a_from_t = 1'b1; o.a_sel = 2'd2; o.b_row = 2'd0; o.b_col = 2'd2;
                  o.fin = 1'b1; end
      default: o = '0;
    endcase
    return o;
  endfunction

  // Matrix entry of determinant d; d above zero swaps column d-1 for the z sums.
  function automatic logic [ENT_W-1:0] ent(input job_t j, input logic [1:0] d,
                                           input logic [1:0] r, input logic [1:0] c);
    logic [ENT_W-1:0] e;
    if ((d != 2'd0) && (c == d - 2'd1)) begin
      unique case (r)
        2'd0:    e = ENT_W'(signed'(j.sxz));
        2'd1:    e = ENT_W'(signed'(j.syz));
        2'd2:    e = ENT_W'(signed'(j.sz));
        default: e = '0;
      endcase
    end else begin
      unique case ({r, c})
        4'b0000: e = ENT_W'(signed'(j.sxx));
        4'b0001: e = ENT_W'(signed'(j.sxy));
        4'b0010: e = ENT_W'(signed'(j.sx));
        4'b0100: e = ENT_W'(signed'(j.sxy));
        4'b0101: e = ENT_W'(signed'(j.syy));
        4'b0110: e = ENT_W'(signed'(j.sy));
        4'b1000: e = ENT_W'(signed'(j.sx));
        4'b1001: e = ENT_W'(signed'(j.sy));
        4'b1010: e = ENT_W'(j.cnt);
        default: e = '0;
      endcase
    end
    return e;
  endfunction

  b_state_t state_r, state_nxt;

  job_t               job_r;
  logic [1:0]         d_r;
  logic [1:0]         k_r;
  logic [STEP_W-1:0]  s_r;
  logic [MBIT_W-1:0]  mbit_r;
  logic [DBIT_W-1:0]  dbit_r;
  logic [BIG_W-1:0]   a_sh_r;
  logic [ENT_W-1:0]   b_sh_r;
  logic [BIG_W-1:0]   prod_r;
  logic [BIG_W-1:0]   acc_r;
  logic [BIG_W-1:0]   t_r [3];
  logic [BIG_W-1:0]   det_r [NUM_DETS];
  logic [BIG_W-1:0]   num_r;
  logic [BIG_W-1:0]   den_r;
  logic [BIG_W-1:0]   rem_r;
  logic [BIG_W-1:0]   q_r;
  logic               neg_r;
  logic               sat_r;
  logic [RES_W-1:0]   res_r [NUM_QUOTS];
  status_t            status_r;

  mac_op_t            op;
  logic [BIG_W-1:0]   a_src;
  logic [BIG_W-1:0]   addend;
  logic [BIG_W-1:0]   mac_sum;
  logic [BIG_W-1:0]   det_abs;
  logic               singular;
  logic [BIG_W-1:0]   num_sel;
  logic [BIG_W:0]     rem2;
  logic               ge;
  logic [RES_W-1:0]   lim;
  logic               sat_k;
  logic [RES_W-1:0]   quot;
  logic               early_fail;

  assign op     = mac_op(s_r);
  assign a_src  = op.a_from_t ? t_r[op.a_sel]
                              : BIG_W'(signed'(ent(job_r, d_r, op.a_row, op.a_col)));
  assign addend = b_sh_r[0] ? a_sh_r : '0;
  assign mac_sum = (op.clr ? '0 : acc_r) + (op.neg ? -prod_r : prod_r);

  assign det_abs  = det_r[0][BIG_W-1] ? -det_r[0] : det_r[0];
  assign singular = (det_r[0] == '0) || (det_abs < BIG_W'(min_det));

  always_comb begin
    unique case (k_r)
      2'd0:    num_sel = det_r[1] << FRAC_BITS;
      2'd1:    num_sel = det_r[2] << FRAC_BITS;
      default: num_sel = det_r[3];
    endcase
  end

  assign rem2 = {rem_r, num_r[BIG_W-1]};
  assign ge   = (rem2 >= {1'b0, den_r});

  assign lim   = neg_r ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
  assign sat_k = (|q_r[BIG_W-1:RES_W]) || (q_r[RES_W-1:0] > lim);
  assign quot  = sat_k ? lim : (neg_r ? -q_r[RES_W-1:0] : q_r[RES_W-1:0]);

  assign early_fail = q_data.ovf || (q_data.cnt < CNT_W'(MIN_FIT_POINTS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = early_fail ? B_OUT : B_MLOAD;
      end
      B_MLOAD: state_nxt = B_MRUN;
      B_MRUN: if (mbit_r == MBIT_W'(ENT_W - 1)) state_nxt = B_MACC;
      B_MACC: begin
        if (!op.fin) begin
          state_nxt = B_MLOAD;
        end else if (d_r == 2'd0) begin
          state_nxt = B_SING;
        end else if (d_r == 2'(NUM_DETS - 1)) begin
          state_nxt = B_DLOAD;
        end else begin
          state_nxt = B_MLOAD;
        end
      end
      B_SING:  state_nxt = singular ? B_OUT : B_MLOAD;
      B_DLOAD: state_nxt = B_DRUN;
      B_DRUN:  if (dbit_r == DBIT_W'(BIG_W - 1)) state_nxt = B_DFIN;
      B_DFIN:  state_nxt = (k_r == 2'(NUM_QUOTS - 1)) ? B_OUT : B_DLOAD;
      B_OUT:   state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty;
    out_valid = (state_r == B_OUT);
  end

  assign out_fit = '{slope_x: res_r[0], slope_y: res_r[1], offset: res_r[2],
                     fit_status: status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        job_r <= q_data;
        d_r   <= '0;
        s_r   <= '0;
        k_r   <= '0;
        sat_r <= 1'b0;
        if (!q_empty && early_fail) begin
          res_r[0] <= '0;
          res_r[1] <= '0;
          res_r[2] <= '0;
          status_r <= q_data.ovf ? ST_MANY : ST_FEW;
        end
      end
      B_MLOAD: begin
        a_sh_r <= a_src;
        b_sh_r <= ent(job_r, d_r, op.b_row, op.b_col);
        prod_r <= '0;
        mbit_r <= '0;
      end
      B_MRUN: begin
        // The top multiplier bit weighs negative: subtract its partial product.
        prod_r <= (mbit_r == MBIT_W'(ENT_W - 1)) ? prod_r - addend : prod_r + addend;
        a_sh_r <= a_sh_r << 1;
        b_sh_r <= b_sh_r >> 1;
        mbit_r <= mbit_r + 1'b1;
      end
      B_MACC: begin
        acc_r <= mac_sum;
        if (op.st_t) t_r[op.t_idx] <= mac_sum;
        if (op.fin) begin
          det_r[d_r] <= mac_sum;
          if ((d_r != 2'd0) && (d_r != 2'(NUM_DETS - 1))) begin
            d_r <= d_r + 1'b1;
            s_r <= '0;
          end
        end else begin
          s_r <= s_r + 1'b1;
        end
      end
      B_SING: begin
        d_r <= 2'd1;
        s_r <= '0;
        if (singular) begin
          res_r[0] <= '0;
          res_r[1] <= '0;
          res_r[2] <= '0;
          status_r <= ST_SING;
        end
      end
      B_DLOAD: begin
        neg_r  <= num_sel[BIG_W-1] ^ det_r[0][BIG_W-1];
        num_r  <= num_sel[BIG_W-1] ? -num_sel : num_sel;
        den_r  <= det_abs;
        rem_r  <= '0;
        q_r    <= '0;
        dbit_r <= '0;
      end
      B_DRUN: begin
        rem_r  <= ge ? BIG_W'(rem2 - {1'b0, den_r}) : rem2[BIG_W-1:0];
        q_r    <= {q_r[BIG_W-2:0], ge};
        num_r  <= num_r << 1;
        dbit_r <= dbit_r + 1'b1;
      end
      B_DFIN: begin
        res_r[k_r] <= quot;
        sat_r      <= sat_r | sat_k;
        k_r        <= k_r + 1'b1;
        status_r   <= (sat_r || sat_k) ? ST_SAT : ST_OK;
      end
      B_OUT: ;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/lspf_checker.sv */
// Port-level checks of the plane fit unit and their binding to the top level.
`include "least_squares_plane_fit_unit_macros.svh"

module lspf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input lspf_pkg::fit_t                 out_fit,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);
  import lspf_pkg::*;

  logic fail_status;
  logic fields_zero;

  assign fail_status = (out_fit.fit_status == ST_FEW) || (out_fit.fit_status == ST_SING) ||
                       (out_fit.fit_status == ST_MANY);
  assign fields_zero = (out_fit.slope_x == '0) && (out_fit.slope_y == '0) &&
                       (out_fit.offset == '0);

  `LSPF_ASSERT_NEXT(a_result_gap, out_valid, !out_valid)
  `LSPF_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
  `LSPF_ASSERT_SAME(a_failed_fit_zero, out_valid && fail_status, fields_zero)
  `LSPF_ASSERT_SAME(a_cfg_always_ready, cfg_valid, cfg_ready)
  `LSPF_ASSERT_RST(a_reset_quiet, !out_valid && !busy)

endmodule

bind least_squares_plane_fit_unit lspf_checker u_lspf_checker (.*);
